// ===== design/vrvp_pkg.sv =====
// constants, sine table and shared types for the vertex rotate, view and project block
`timescale 1ns / 1ps

package vrvp_pkg;

    localparam int ANGLE_BITS     = 9;
    localparam int ANGLE_REG_BITS = 3 * ANGLE_BITS;
    localparam int DIST_BITS      = 12;
    localparam int DEPTH_BITS     = 10;
    localparam int DEPTH_MAX      = 1000;
    localparam int TAB_FRAC       = 14;
    localparam int TAB_IDX_BITS   = 7;
    localparam int FULL_TURN      = 360;
    localparam int THREE_QUARTER  = 270;
    localparam int HALF_TURN      = 180;
    localparam int QUARTER_TURN   = 90;
    localparam int SCREEN_BITS    = 16;
    localparam int SCREEN_MAX     = 32767;
    localparam int SCREEN_MIN     = -32768;
    localparam int ADDR_BITS      = 5;
    localparam int DATA_BITS      = 32;
    localparam int REG_IDX_BITS   = 3;

    localparam logic [REG_IDX_BITS-1:0] REG_OBJ_ANGLES = 3'd0;
    localparam logic [REG_IDX_BITS-1:0] REG_CAM_ANGLES = 3'd1;
    localparam logic [REG_IDX_BITS-1:0] REG_CAM_X      = 3'd2;
    localparam logic [REG_IDX_BITS-1:0] REG_CAM_Y      = 3'd3;
    localparam logic [REG_IDX_BITS-1:0] REG_CAM_Z      = 3'd4;
    localparam logic [REG_IDX_BITS-1:0] REG_PROJ_DIST  = 3'd5;

    // round(sin(d) * 2^14) for whole degrees 0..90
    localparam int QUARTER_SINE [0:90] = '{
        0, 286, 572, 857, 1143, 1428, 1713, 1997, 2280, 2563,
        2845, 3126, 3406, 3686, 3964, 4240, 4516, 4790, 5063, 5334,
        5604, 5872, 6138, 6402, 6664, 6924, 7182, 7438, 7692, 7943,
        8192, 8438, 8682, 8923, 9162, 9397, 9630, 9860, 10087, 10311,
        10531, 10749, 10963, 11174, 11381, 11585, 11786, 11982, 12176, 12365,
        12551, 12733, 12911, 13085, 13255, 13421, 13583, 13741, 13894, 14044,
        14189, 14330, 14466, 14598, 14726, 14849, 14968, 15082, 15191, 15296,
        15396, 15491, 15582, 15668, 15749, 15826, 15897, 15964, 16026, 16083,
        16135, 16182, 16225, 16262, 16294, 16322, 16344, 16362, 16374, 16382,
        16384
    };

    typedef struct packed {
        logic neg_x;
        logic neg_y;
    } vrvp_sign_t;

endpackage

// ===== design/vrvp_div.sv =====
// pipelined restoring divider, two lanes sharing one divisor, one quotient bit per stage
`timescale 1ns / 1ps

module vrvp_div
    import vrvp_pkg::*;
#(
    parameter int NUM_BITS = 31
)(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  en,
    input  logic                  in_valid,
    input  logic [NUM_BITS-1:0]   in_num_x,
    input  logic [NUM_BITS-1:0]   in_num_y,
    input  logic [DEPTH_BITS-1:0] in_den,
    input  vrvp_sign_t            in_sign,
    output logic                  out_valid,
    output logic [NUM_BITS-1:0]   out_quo_x,
    output logic [NUM_BITS-1:0]   out_quo_y,
    output vrvp_sign_t            out_sign
);

    localparam int LAST    = NUM_BITS - 1;
    localparam int STEP_W  = DEPTH_BITS + NUM_BITS;

    logic                  v_reg     [0:LAST];
    logic [DEPTH_BITS-1:0] rem_x_reg [0:LAST];
    logic [DEPTH_BITS-1:0] rem_y_reg [0:LAST];
    logic [NUM_BITS-1:0]   quo_x_reg [0:LAST];
    logic [NUM_BITS-1:0]   quo_y_reg [0:LAST];
    logic [DEPTH_BITS-1:0] den_reg   [0:LAST];
    vrvp_sign_t            sign_reg  [0:LAST];

    // shift in one numerator bit, subtract the divisor when it fits
    function automatic logic [STEP_W-1:0] div_step(
        input logic [DEPTH_BITS-1:0] rem,
        input logic [NUM_BITS-1:0]   quo,
        input logic [DEPTH_BITS-1:0] den
    );
        logic [DEPTH_BITS:0] t;
        logic                ge;
        t  = {rem, quo[NUM_BITS-1]};
        ge = (t >= {1'b0, den});
        if (ge)
        begin
            t = t - {1'b0, den};
        end
        div_step = {t[DEPTH_BITS-1:0], quo[NUM_BITS-2:0], ge};
    endfunction

    for (genvar k = 0; k < NUM_BITS; k++)
    begin : g_stage
        logic                  v_in;
        logic [DEPTH_BITS-1:0] rem_x_in;
        logic [DEPTH_BITS-1:0] rem_y_in;
        logic [NUM_BITS-1:0]   quo_x_in;
        logic [NUM_BITS-1:0]   quo_y_in;
        logic [DEPTH_BITS-1:0] den_in;
        vrvp_sign_t            sign_in;

        if (k == 0)
        begin : g_first
            assign v_in     = in_valid;
            assign rem_x_in = '0;
            assign rem_y_in = '0;
            assign quo_x_in = in_num_x;
            assign quo_y_in = in_num_y;
            assign den_in   = in_den;
            assign sign_in  = in_sign;
        end
        else
        begin : g_next
            assign v_in     = v_reg[k-1];
            assign rem_x_in = rem_x_reg[k-1];
            assign rem_y_in = rem_y_reg[k-1];
            assign quo_x_in = quo_x_reg[k-1];
            assign quo_y_in = quo_y_reg[k-1];
            assign den_in   = den_reg[k-1];
            assign sign_in  = sign_reg[k-1];
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[k] <= 1'b0;
            end
            else if (en)
            begin
                v_reg[k] <= v_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                {rem_x_reg[k], quo_x_reg[k]} <= div_step(rem_x_in, quo_x_in, den_in);
                {rem_y_reg[k], quo_y_reg[k]} <= div_step(rem_y_in, quo_y_in, den_in);
                den_reg[k]  <= den_in;
                sign_reg[k] <= sign_in;
            end
        end
    end

    assign out_valid = v_reg[LAST];
    assign out_quo_x = quo_x_reg[LAST];
    assign out_quo_y = quo_y_reg[LAST];
    assign out_sign  = sign_reg[LAST];

endmodule

// ===== design/vertex_rotate_view_project_top.sv =====
// top level: object rotation, camera transform and perspective projection pipeline
//
//  channel   direction  handshake              payload
//  config    in/out     psel penable pwrite    paddr pwdata prdata
//  vertex    in         in_valid in_ready      vertex_x vertex_y vertex_z
//  screen    out        out_valid out_ready    screen_x screen_y clipped
//
//  one vertex transfer per cycle while in_ready is high; the result reaches the output
//  register through 13 rotate/transform stages, the COORD_BITS + 19 stage divider for the
//  depth divide and the saturate stage; the camera matrix follows a write through the
//  sine/cosine, product, triple product and matrix registers; object sine/cosine is one register
//  reset sets the configuration registers and clears valid bits, no clearing pass
//  output register plus one skid entry: a stalled result still lets one more transfer in,
//  then in_ready drops until the skid entry drains
`timescale 1ns / 1ps

module vertex_rotate_view_project_top
    import vrvp_pkg::*;
#(
    parameter int COORD_BITS     = 12,
    parameter int TRIG_FRAC_BITS = 14
)(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [ADDR_BITS-1:0]         paddr,
    input  logic [DATA_BITS-1:0]         pwdata,
    output logic [DATA_BITS-1:0]         prdata,
    output logic                         pready,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic signed [COORD_BITS-1:0] vertex_x,
    input  logic signed [COORD_BITS-1:0] vertex_y,
    input  logic signed [COORD_BITS-1:0] vertex_z,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic signed [SCREEN_BITS-1:0] screen_x,
    output logic signed [SCREEN_BITS-1:0] screen_y,
    output logic                         clipped
);

    localparam int C    = COORD_BITS;
    localparam int F    = TRIG_FRAC_BITS;
    localparam int TW   = F + 2;
    localparam int PW   = C + TW;
    localparam int AW   = C + F + 4;
    localparam int QW   = AW + TW;
    localparam int DW   = C + 4;
    localparam int MW   = F + 3;
    localparam int SW   = DW + MW;
    localparam int VW   = C + 8;
    localparam int MAGW = VW - 1;
    localparam int NB   = MAGW + DIST_BITS;
    localparam int UP   = (F >= TAB_FRAC) ? F - TAB_FRAC : 0;
    localparam int DN   = (F < TAB_FRAC) ? TAB_FRAC - F : 0;
    localparam int RND  = (1 << DN) >> 1;
    localparam int FRONT_LAST = 12;

    localparam logic signed [2*TW-1:0] BIAS_T = (2*TW)'((1 << F) - 1);
    localparam logic signed [QW-1:0]   BIAS_Q = QW'((1 << F) - 1);
    localparam logic signed [AW-1:0]   BIAS_A = AW'((1 << F) - 1);
    localparam logic signed [SW-1:0]   BIAS_S = SW'((1 << F) - 1);

    // ---------------- helpers ----------------

    function automatic logic [ANGLE_BITS-1:0] wrap_angle(input logic [ANGLE_BITS-1:0] a);
        wrap_angle = (a >= ANGLE_BITS'(FULL_TURN)) ? a - ANGLE_BITS'(FULL_TURN) : a;
    endfunction

    function automatic logic signed [TW-1:0] sin_q(input logic [ANGLE_BITS-1:0] d);
        logic [ANGLE_BITS-1:0] q;
        logic                  neg;
        int                    v;
        if (d <= ANGLE_BITS'(QUARTER_TURN))
        begin
            q   = d;
            neg = 1'b0;
        end
        else if (d <= ANGLE_BITS'(HALF_TURN))
        begin
            q   = ANGLE_BITS'(HALF_TURN) - d;
            neg = 1'b0;
        end
        else if (d <= ANGLE_BITS'(THREE_QUARTER))
        begin
            q   = d - ANGLE_BITS'(HALF_TURN);
            neg = 1'b1;
        end
        else
        begin
            q   = ANGLE_BITS'(FULL_TURN) - d;
            neg = 1'b1;
        end
        v = QUARTER_SINE[q[TAB_IDX_BITS-1:0]];
        if (DN > 0)
        begin
            v = (v + RND) >>> DN;
        end
        else
        begin
            v = v <<< UP;
        end
        if (neg)
        begin
            v = -v;
        end
        sin_q = TW'(v);
    endfunction

    function automatic logic signed [TW-1:0] cos_q(input logic [ANGLE_BITS-1:0] d);
        cos_q = sin_q(wrap_angle(d + ANGLE_BITS'(QUARTER_TURN)));
    endfunction

    // product of two trig values, fraction dropped toward zero
    function automatic logic signed [TW-1:0] mq_t(
        input logic signed [TW-1:0] a,
        input logic signed [TW-1:0] b
    );
        logic signed [2*TW-1:0] p;
        p = a * b;
        p = p + (p[2*TW-1] ? BIAS_T : '0);
        mq_t = TW'(p >>> F);
    endfunction

    function automatic logic signed [AW-1:0] tz_q(input logic signed [QW-1:0] p);
        logic signed [QW-1:0] b;
        b = p + (p[QW-1] ? BIAS_Q : '0);
        tz_q = AW'(b >>> F);
    endfunction

    function automatic logic signed [DW-1:0] tz_a(input logic signed [AW-1:0] p);
        logic signed [AW-1:0] b;
        b = p + (p[AW-1] ? BIAS_A : '0);
        tz_a = DW'(b >>> F);
    endfunction

    function automatic logic signed [VW-1:0] tz_s(input logic signed [SW-1:0] p);
        logic signed [SW-1:0] b;
        b = p + (p[SW-1] ? BIAS_S : '0);
        tz_s = VW'(b >>> F);
    endfunction

    // {clip, value}
    function automatic logic [SCREEN_BITS:0] sat_q(input logic [NB-1:0] q, input logic neg);
        logic [SCREEN_BITS-1:0] lo;
        lo = q[SCREEN_BITS-1:0];
        if (!neg)
        begin
            if (q > NB'(SCREEN_MAX))
                sat_q = {1'b1, SCREEN_BITS'(SCREEN_MAX)};
            else
                sat_q = {1'b0, lo};
        end
        else
        begin
            if (q > NB'(SCREEN_MAX + 1))
                sat_q = {1'b1, SCREEN_BITS'(SCREEN_MIN)};
            else
                sat_q = {1'b0, SCREEN_BITS'(~lo + 1'b1)};
        end
    endfunction

    // ---------------- configuration ----------------

    logic [ANGLE_REG_BITS-1:0] obj_angles_reg;
    logic [ANGLE_REG_BITS-1:0] cam_angles_reg;
    logic signed [C-1:0]       cam_x_reg;
    logic signed [C-1:0]       cam_y_reg;
    logic signed [C-1:0]       cam_z_reg;
    logic [DIST_BITS-1:0]      dist_reg;
    logic                      cfg_write;
    logic [REG_IDX_BITS-1:0]   cfg_idx;

    assign pready    = 1'b1;
    assign cfg_write = psel & penable & pwrite;
    assign cfg_idx   = paddr[ADDR_BITS-1:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            obj_angles_reg <= '0;
            cam_angles_reg <= '0;
            cam_x_reg      <= '0;
            cam_y_reg      <= '0;
            cam_z_reg      <= '0;
            dist_reg       <= DIST_BITS'(1);
        end
        else if (cfg_write)
        begin
            unique case (cfg_idx)
                REG_OBJ_ANGLES: obj_angles_reg <= pwdata[ANGLE_REG_BITS-1:0];
                REG_CAM_ANGLES: cam_angles_reg <= pwdata[ANGLE_REG_BITS-1:0];
                REG_CAM_X:      cam_x_reg      <= pwdata[C-1:0];
                REG_CAM_Y:      cam_y_reg      <= pwdata[C-1:0];
                REG_CAM_Z:      cam_z_reg      <= pwdata[C-1:0];
                REG_PROJ_DIST:  dist_reg       <= pwdata[DIST_BITS-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (cfg_idx)
            REG_OBJ_ANGLES: prdata = DATA_BITS'(obj_angles_reg);
            REG_CAM_ANGLES: prdata = DATA_BITS'(cam_angles_reg);
            REG_CAM_X:      prdata = DATA_BITS'($unsigned(cam_x_reg));
            REG_CAM_Y:      prdata = DATA_BITS'($unsigned(cam_y_reg));
            REG_CAM_Z:      prdata = DATA_BITS'($unsigned(cam_z_reg));
            REG_PROJ_DIST:  prdata = DATA_BITS'(dist_reg);
            default:        prdata = '0;
        endcase
    end

    // ---------------- sine/cosine and camera matrix ----------------

    logic [ANGLE_BITS-1:0] oax, oay, oaz, cax, cay, caz;

    assign oax = wrap_angle(obj_angles_reg[ANGLE_BITS-1:0]);
    assign oay = wrap_angle(obj_angles_reg[2*ANGLE_BITS-1:ANGLE_BITS]);
    assign oaz = wrap_angle(obj_angles_reg[3*ANGLE_BITS-1:2*ANGLE_BITS]);
    assign cax = wrap_angle(cam_angles_reg[ANGLE_BITS-1:0]);
    assign cay = wrap_angle(cam_angles_reg[2*ANGLE_BITS-1:ANGLE_BITS]);
    assign caz = wrap_angle(cam_angles_reg[3*ANGLE_BITS-1:2*ANGLE_BITS]);

    logic signed [TW-1:0] osx_reg, ocx_reg, osy_reg, ocy_reg, osz_reg, ocz_reg;
    logic signed [TW-1:0] csx_reg, ccx_reg, csy_reg, ccy_reg, csz_reg, ccz_reg;
    logic signed [TW-1:0] cycz_reg, cysz_reg, sxsy_reg, cxsy_reg, cxsz_reg;
    logic signed [TW-1:0] sxsz_reg, sxcz_reg, cxcz_reg, sxcy_reg, cxcy_reg;
    logic signed [TW-1:0] sxsycz_reg, sxsysz_reg, cxsycz_reg, cxsysz_reg;
    logic signed [MW-1:0] m00_reg, m01_reg, m02_reg;
    logic signed [MW-1:0] m10_reg, m11_reg, m12_reg;
    logic signed [MW-1:0] m20_reg, m21_reg, m22_reg;

    always_ff @(posedge clk)
    begin
        osx_reg <= sin_q(oax);
        ocx_reg <= cos_q(oax);
        osy_reg <= sin_q(oay);
        ocy_reg <= cos_q(oay);
        osz_reg <= sin_q(oaz);
        ocz_reg <= cos_q(oaz);
        csx_reg <= sin_q(cax);
        ccx_reg <= cos_q(cax);
        csy_reg <= sin_q(cay);
        ccy_reg <= cos_q(cay);
        csz_reg <= sin_q(caz);
        ccz_reg <= cos_q(caz);

        cycz_reg <= mq_t(ccy_reg, ccz_reg);
        cysz_reg <= mq_t(ccy_reg, csz_reg);
        sxsy_reg <= mq_t(csx_reg, csy_reg);
        cxsy_reg <= mq_t(ccx_reg, csy_reg);
        cxsz_reg <= mq_t(ccx_reg, csz_reg);
        sxsz_reg <= mq_t(csx_reg, csz_reg);
        sxcz_reg <= mq_t(csx_reg, ccz_reg);
        cxcz_reg <= mq_t(ccx_reg, ccz_reg);
        sxcy_reg <= mq_t(csx_reg, ccy_reg);
        cxcy_reg <= mq_t(ccx_reg, ccy_reg);

        sxsycz_reg <= mq_t(sxsy_reg, ccz_reg);
        sxsysz_reg <= mq_t(sxsy_reg, csz_reg);
        cxsycz_reg <= mq_t(cxsy_reg, ccz_reg);
        cxsysz_reg <= mq_t(cxsy_reg, csz_reg);

        m00_reg <= MW'(cycz_reg);
        m01_reg <= MW'(cysz_reg);
        m02_reg <= -MW'(csy_reg);
        m10_reg <= MW'(sxsycz_reg) - MW'(cxsz_reg);
        m11_reg <= MW'(sxsysz_reg) + MW'(cxcz_reg);
        m12_reg <= MW'(sxcy_reg);
        m20_reg <= MW'(cxsycz_reg) + MW'(sxsz_reg);
        m21_reg <= MW'(cxsysz_reg) - MW'(sxcz_reg);
        m22_reg <= MW'(cxcy_reg);
    end

    // ---------------- vertex pipeline ----------------

    logic en;
    logic skid_valid_reg;
    logic v_reg [0:FRONT_LAST];

    assign en       = ~skid_valid_reg;
    assign in_ready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k <= FRONT_LAST; k++)
            begin
                v_reg[k] <= 1'b0;
            end
        end
        else if (en)
        begin
            v_reg[0] <= in_valid;
            for (int k = 1; k <= FRONT_LAST; k++)
            begin
                v_reg[k] <= v_reg[k-1];
            end
        end
    end

    logic signed [C-1:0]    x0_reg, y0_reg, z0_reg;
    logic signed [PW-1:0]   pyc1_reg, pzs1_reg, pys1_reg, pzc1_reg, pxc1_reg, pxs1_reg;
    logic signed [AW-1:0]   y1_2_reg, z1_2_reg;
    logic signed [PW-1:0]   pxc2_reg, pxs2_reg;
    logic signed [QW-1:0]   pzs3_reg, pzc3_reg;
    logic signed [AW-1:0]   y1_3_reg;
    logic signed [PW-1:0]   pxc3_reg, pxs3_reg;
    logic signed [AW-1:0]   x2_4_reg, z2_4_reg, y1_4_reg;
    logic signed [QW-1:0]   pa5_reg, pb5_reg, pc5_reg, pd5_reg;
    logic signed [AW-1:0]   z2_5_reg;
    logic signed [AW-1:0]   x3_6_reg, y3_6_reg, z2_6_reg;
    logic signed [DW-1:0]   dx7_reg, dy7_reg, dz7_reg;
    logic signed [SW-1:0]   px0_reg, px1_reg, px2_reg;
    logic signed [SW-1:0]   py0_reg, py1_reg, py2_reg;
    logic signed [SW-1:0]   pz0_reg, pz1_reg, pz2_reg;
    logic signed [SW-1:0]   sx9_reg, sy9_reg, sz9_reg;
    logic signed [VW-1:0]   vx10_reg, vy10_reg;
    logic [DEPTH_BITS-1:0]  depth10_reg, depth11_reg, depth12_reg;
    logic [MAGW-1:0]        magx11_reg, magy11_reg;
    vrvp_sign_t             sign11_reg, sign12_reg;
    logic [NB-1:0]          numx12_reg, numy12_reg;

    logic signed [VW-1:0]   vz_c;
    logic [DEPTH_BITS-1:0]  depth_c;

    always_comb
    begin
        vz_c = tz_s(sz9_reg);
        if (vz_c < VW'(1))
            depth_c = DEPTH_BITS'(1);
        else if (vz_c > VW'(DEPTH_MAX))
            depth_c = DEPTH_BITS'(DEPTH_MAX);
        else
            depth_c = vz_c[DEPTH_BITS-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x0_reg <= vertex_x;
            y0_reg <= vertex_y;
            z0_reg <= vertex_z;

            // rotation about x
            pyc1_reg <= y0_reg * ocx_reg;
            pzs1_reg <= z0_reg * osx_reg;
            pys1_reg <= y0_reg * osx_reg;
            pzc1_reg <= z0_reg * ocx_reg;
            pxc1_reg <= x0_reg * ocy_reg;
            pxs1_reg <= x0_reg * osy_reg;

            y1_2_reg <= AW'(pyc1_reg) - AW'(pzs1_reg);
            z1_2_reg <= AW'(pys1_reg) + AW'(pzc1_reg);
            pxc2_reg <= pxc1_reg;
            pxs2_reg <= pxs1_reg;

            // rotation about y
            pzs3_reg <= z1_2_reg * osy_reg;
            pzc3_reg <= z1_2_reg * ocy_reg;
            y1_3_reg <= y1_2_reg;
            pxc3_reg <= pxc2_reg;
            pxs3_reg <= pxs2_reg;

            x2_4_reg <= AW'(pxc3_reg) + tz_q(pzs3_reg);
            z2_4_reg <= tz_q(pzc3_reg) - AW'(pxs3_reg);
            y1_4_reg <= y1_3_reg;

            // rotation about z
            pa5_reg  <= x2_4_reg * ocz_reg;
            pb5_reg  <= y1_4_reg * osz_reg;
            pc5_reg  <= x2_4_reg * osz_reg;
            pd5_reg  <= y1_4_reg * ocz_reg;
            z2_5_reg <= z2_4_reg;

            x3_6_reg <= tz_q(pa5_reg) - tz_q(pb5_reg);
            y3_6_reg <= tz_q(pc5_reg) + tz_q(pd5_reg);
            z2_6_reg <= z2_5_reg;

            // camera offset
            dx7_reg <= tz_a(x3_6_reg) - DW'(cam_x_reg);
            dy7_reg <= tz_a(y3_6_reg) - DW'(cam_y_reg);
            dz7_reg <= tz_a(z2_6_reg) - DW'(cam_z_reg);

            // camera matrix
            px0_reg <= dx7_reg * m00_reg;
            px1_reg <= dy7_reg * m01_reg;
            px2_reg <= dz7_reg * m02_reg;
            py0_reg <= dx7_reg * m10_reg;
            py1_reg <= dy7_reg * m11_reg;
            py2_reg <= dz7_reg * m12_reg;
            pz0_reg <= dx7_reg * m20_reg;
            pz1_reg <= dy7_reg * m21_reg;
            pz2_reg <= dz7_reg * m22_reg;

            sx9_reg <= px0_reg + px1_reg + px2_reg;
            sy9_reg <= py0_reg + py1_reg + py2_reg;
            sz9_reg <= pz0_reg + pz1_reg + pz2_reg;

            vx10_reg    <= tz_s(sx9_reg);
            vy10_reg    <= tz_s(sy9_reg);
            depth10_reg <= depth_c;

            // sign and magnitude for the divider
            magx11_reg       <= MAGW'(vx10_reg[VW-1] ? -vx10_reg : vx10_reg);
            magy11_reg       <= MAGW'(vy10_reg[VW-1] ? -vy10_reg : vy10_reg);
            sign11_reg.neg_x <= vx10_reg[VW-1];
            sign11_reg.neg_y <= vy10_reg[VW-1];
            depth11_reg      <= depth10_reg;

            numx12_reg  <= magx11_reg * dist_reg;
            numy12_reg  <= magy11_reg * dist_reg;
            sign12_reg  <= sign11_reg;
            depth12_reg <= depth11_reg;
        end
    end

    // ---------------- depth divide ----------------

    logic          div_valid;
    logic [NB-1:0] div_quo_x;
    logic [NB-1:0] div_quo_y;
    vrvp_sign_t    div_sign;

    vrvp_div #(
        .NUM_BITS (NB)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (v_reg[FRONT_LAST]),
        .in_num_x  (numx12_reg),
        .in_num_y  (numy12_reg),
        .in_den    (depth12_reg),
        .in_sign   (sign12_reg),
        .out_valid (div_valid),
        .out_quo_x (div_quo_x),
        .out_quo_y (div_quo_y),
        .out_sign  (div_sign)
    );

    // ---------------- saturate ----------------

    logic [SCREEN_BITS:0]   sat_x, sat_y;
    logic                   fin_valid_reg;
    logic [SCREEN_BITS-1:0] fin_x_reg, fin_y_reg;
    logic                   fin_clip_reg;

    assign sat_x = sat_q(div_quo_x, div_sign.neg_x);
    assign sat_y = sat_q(div_quo_y, div_sign.neg_y);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fin_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            fin_valid_reg <= div_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            fin_x_reg    <= sat_x[SCREEN_BITS-1:0];
            fin_y_reg    <= sat_y[SCREEN_BITS-1:0];
            fin_clip_reg <= sat_x[SCREEN_BITS] | sat_y[SCREEN_BITS];
        end
    end

    // ---------------- output register and skid entry ----------------

    logic                   out_valid_reg;
    logic [SCREEN_BITS-1:0] out_x_reg, out_y_reg;
    logic                   out_clip_reg;
    logic [SCREEN_BITS-1:0] skid_x_reg, skid_y_reg;
    logic                   skid_clip_reg;
    logic                   out_free;
    logic                   fin_move;

    assign out_free = ~out_valid_reg | out_ready;
    assign fin_move = en & fin_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg  <= skid_valid_reg | fin_move;
            skid_valid_reg <= 1'b0;
        end
        else if (fin_move)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_free)
        begin
            if (skid_valid_reg)
            begin
                out_x_reg    <= skid_x_reg;
                out_y_reg    <= skid_y_reg;
                out_clip_reg <= skid_clip_reg;
            end
            else
            begin
                out_x_reg    <= fin_x_reg;
                out_y_reg    <= fin_y_reg;
                out_clip_reg <= fin_clip_reg;
            end
        end
        else if (fin_move)
        begin
            skid_x_reg    <= fin_x_reg;
            skid_y_reg    <= fin_y_reg;
            skid_clip_reg <= fin_clip_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign screen_x  = out_x_reg;
    assign screen_y  = out_y_reg;
    assign clipped   = out_clip_reg;

`ifndef NO_ASSERTIONS
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry held without an output transfer pending");

    a_skid_fill: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(skid_valid_reg) |-> $past(out_valid_reg && !out_ready))
        else $error("skid entry filled while the output was free");

    a_clip_extreme: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_clip_reg) |->
            (out_x_reg == SCREEN_BITS'(SCREEN_MAX) || out_x_reg == SCREEN_BITS'(SCREEN_MIN) ||
             out_y_reg == SCREEN_BITS'(SCREEN_MAX) || out_y_reg == SCREEN_BITS'(SCREEN_MIN)))
        else $error("clip flag without a saturated coordinate");

    a_depth_range: assert property (@(posedge clk) disable iff (!rst_n)
        v_reg[10] |-> (depth10_reg != '0 && depth10_reg <= DEPTH_BITS'(DEPTH_MAX)))
        else $error("depth divisor outside its clamp range");
`endif

endmodule
